// ===== design/oatc_pkg.sv =====
// ----------------------------------------------------------------------------
// Obstacle avoid turn controller package
// Shared widths, codes and structures for the turn controller and its scan
// window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package oatc_pkg;

    localparam int MAX_SCAN = 4096;
    localparam int IDX_W    = $clog2(MAX_SCAN);

    localparam int RANGE_W  = 16;
    localparam int SKIP_W   = 10;
    localparam int SCAN_W   = 13;
    localparam int ZAI_W    = 12;
    localparam int TICK_W   = 16;
    localparam int STEP_W   = 6;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int SUM_W = ((IDX_W > SCAN_W) ? IDX_W : SCAN_W) + 1;
    localparam int CMP_W = (IDX_W > ZAI_W) ? IDX_W : ZAI_W;

    localparam logic [IDX_W-1:0]   IDX_MAX   = IDX_W'(MAX_SCAN - 1);
    localparam logic [RANGE_W-1:0] RANGE_MAX = '1;
    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_ADVANCE = 2'd1,
        MODE_TURN    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DRV_STOP  = 2'd0,
        DRV_FWD   = 2'd1,
        DRV_RIGHT = 2'd2,
        DRV_LEFT  = 2'd3
    } drive_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_EDGE_SKIP  = 3'd1,
        CFG_SCAN_LEN   = 3'd2,
        CFG_ZERO_ANGLE = 3'd3,
        CFG_WAIT_TICKS = 3'd4,
        CFG_STEP_LIMIT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [SKIP_W-1:0] edge_skip;
        logic [SCAN_W-1:0] scan_length;
    } win_cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] min_mm;
        logic [IDX_W-1:0]   min_idx;
    } win_t;

endpackage

`default_nettype wire

// ===== design/oatc_window.sv =====
// ----------------------------------------------------------------------------
// Scan window minimum tracker
// Counts samples within a scan and keeps the first minimum range inside the
// window that leaves out edge_skip samples at each end.
// ----------------------------------------------------------------------------
`default_nettype none

module oatc_window
    import oatc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               scan_end,
    input  wire logic [RANGE_W-1:0] range_mm,
    input  wire win_cfg_t           cfg,
    output win_t                    win
);

    logic [IDX_W-1:0]   sample_index_reg;
    logic [IDX_W-1:0]   sample_index_next;
    logic [RANGE_W-1:0] min_reg;
    logic [RANGE_W-1:0] min_next;
    logic [IDX_W-1:0]   min_idx_reg;
    logic [IDX_W-1:0]   min_idx_next;
    logic               in_window;
    logic [SUM_W-1:0]   far_edge;

    always_comb
    begin
        far_edge  = SUM_W'(sample_index_reg) + SUM_W'(cfg.edge_skip);
        in_window = (SUM_W'(sample_index_reg) >= SUM_W'(cfg.edge_skip))
                    && (far_edge < SUM_W'(cfg.scan_length))
                    && (range_mm < min_reg);
        win.min_mm  = in_window ? range_mm : min_reg;
        win.min_idx = in_window ? sample_index_reg : min_idx_reg;

        sample_index_next = sample_index_reg;
        min_next          = min_reg;
        min_idx_next      = min_idx_reg;
        if (step)
        begin
            if (scan_end)
            begin
                sample_index_next = '0;
                min_next          = RANGE_MAX;
                min_idx_next      = '0;
            end
            else
            begin
                if (sample_index_reg != IDX_MAX)
                begin
                    sample_index_next = sample_index_reg + 1'b1;
                end
                min_next     = win.min_mm;
                min_idx_next = win.min_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            min_reg          <= RANGE_MAX;
            min_idx_reg      <= '0;
        end
        else
        begin
            sample_index_reg <= sample_index_next;
            min_reg          <= min_next;
            min_idx_reg      <= min_idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/obstacle_avoid_turn_controller.sv =====
// ----------------------------------------------------------------------------
// Obstacle avoid turn controller
// Tracks the minimum laser range of each scan and runs the start, advance and
// turn mode machine at every scan end to issue drive commands.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    op, range_mm, last
// out       output     out_valid/out_stall  mode, drive, sent, left_avoided,
//                                           right_avoided, scan_min_mm
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One item per cycle is sustained while out_stall is low; each item waits in
// the input register while the state update is computed, and its result is
// offered from the state registers, which themselves form the result
// register. A stalled result holds the state, and one more item waits in the
// input register. Reset clears all state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_avoid_turn_controller
    import oatc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 op,
    input  wire logic [RANGE_W-1:0]   range_mm,
    input  wire logic                 last,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                mode,
    output logic [1:0]                drive,
    output logic                      sent,
    output logic [COUNT_W-1:0]        left_avoided,
    output logic [COUNT_W-1:0]        right_avoided,
    output logic [RANGE_W-1:0]        scan_min_mm,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [RANGE_W-1:0] threshold_reg;
    logic [SKIP_W-1:0]  edge_skip_reg;
    logic [SCAN_W-1:0]  scan_length_reg;
    logic [ZAI_W-1:0]   zero_angle_reg;
    logic [TICK_W-1:0]  wait_ticks_reg;
    logic [STEP_W-1:0]  step_limit_reg;

    logic               in_valid_reg;
    logic               op_reg;
    logic [RANGE_W-1:0] range_reg;
    logic               last_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               sent_reg;
    logic               sent_next;
    mode_t              mode_reg;
    mode_t              mode_next;
    drive_t             drive_reg;
    drive_t             drive_next;
    logic [TICK_W-1:0]  elapsed_reg;
    logic [TICK_W-1:0]  elapsed_next;
    logic [STEP_W-1:0]  turn_steps_reg;
    logic [STEP_W-1:0]  turn_steps_next;
    logic [COUNT_W-1:0] left_count_reg;
    logic [COUNT_W-1:0] left_count_next;
    logic [COUNT_W-1:0] right_count_reg;
    logic [COUNT_W-1:0] right_count_next;
    logic [RANGE_W-1:0] scan_min_reg;
    logic [RANGE_W-1:0] scan_min_next;

    logic               advance;
    logic               sample_step;
    logic               scan_end;
    logic               blocked;
    win_cfg_t           win_cfg;
    win_t               win;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= RANGE_W'(500);
            edge_skip_reg   <= SKIP_W'(100);
            scan_length_reg <= SCAN_W'(600);
            zero_angle_reg  <= ZAI_W'(300);
            wait_ticks_reg  <= TICK_W'(1000);
            step_limit_reg  <= STEP_W'(18);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD:  threshold_reg   <= cfg_data[RANGE_W-1:0];
                CFG_EDGE_SKIP:  edge_skip_reg   <= cfg_data[SKIP_W-1:0];
                CFG_SCAN_LEN:   scan_length_reg <= cfg_data[SCAN_W-1:0];
                CFG_ZERO_ANGLE: zero_angle_reg  <= cfg_data[ZAI_W-1:0];
                CFG_WAIT_TICKS: wait_ticks_reg  <= cfg_data[TICK_W-1:0];
                CFG_STEP_LIMIT: step_limit_reg  <= cfg_data[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg    <= op;
            range_reg <= range_mm;
            last_reg  <= last;
        end
    end

    assign sample_step         = advance && !op_reg;
    assign scan_end            = sample_step && last_reg;
    assign win_cfg.edge_skip   = edge_skip_reg;
    assign win_cfg.scan_length = scan_length_reg;

    oatc_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (sample_step),
        .scan_end (last_reg),
        .range_mm (range_reg),
        .cfg      (win_cfg),
        .win      (win)
    );

    assign blocked = win.min_mm < threshold_reg;

    always_comb
    begin
        out_valid_next   = advance || (out_valid_reg && out_stall);
        sent_next        = sent_reg;
        mode_next        = mode_reg;
        drive_next       = drive_reg;
        elapsed_next     = elapsed_reg;
        turn_steps_next  = turn_steps_reg;
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        scan_min_next    = scan_min_reg;

        if (advance)
        begin
            sent_next = 1'b0;
            if (op_reg && (elapsed_reg != TICK_MAX))
            begin
                elapsed_next = elapsed_reg + 1'b1;
            end
        end

        if (scan_end)
        begin
            scan_min_next = win.min_mm;
            case (mode_reg)
                MODE_START:
                begin
                    drive_next      = DRV_FWD;
                    sent_next       = 1'b1;
                    turn_steps_next = '0;
                    mode_next       = MODE_ADVANCE;
                end
                MODE_ADVANCE:
                begin
                    if (blocked)
                    begin
                        elapsed_next = '0;
                        if (CMP_W'(win.min_idx) > CMP_W'(zero_angle_reg))
                        begin
                            left_count_next = left_count_reg + 1'b1;
                            drive_next      = DRV_RIGHT;
                        end
                        else
                        begin
                            right_count_next = right_count_reg + 1'b1;
                            drive_next       = DRV_LEFT;
                        end
                        sent_next       = 1'b1;
                        turn_steps_next = STEP_W'(1);
                        mode_next       = MODE_TURN;
                    end
                end
                MODE_TURN:
                begin
                    if (elapsed_reg > wait_ticks_reg)
                    begin
                        if (blocked && (turn_steps_reg < step_limit_reg))
                        begin
                            elapsed_next    = '0;
                            sent_next       = 1'b1;
                            turn_steps_next = turn_steps_reg + 1'b1;
                        end
                        else
                        begin
                            drive_next = DRV_STOP;
                            mode_next  = MODE_START;
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            sent_reg        <= 1'b0;
            mode_reg        <= MODE_START;
            drive_reg       <= DRV_FWD;
            elapsed_reg     <= '0;
            turn_steps_reg  <= '0;
            left_count_reg  <= '0;
            right_count_reg <= '0;
            scan_min_reg    <= RANGE_MAX;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            sent_reg        <= sent_next;
            mode_reg        <= mode_next;
            drive_reg       <= drive_next;
            elapsed_reg     <= elapsed_next;
            turn_steps_reg  <= turn_steps_next;
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
            scan_min_reg    <= scan_min_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mode          = mode_reg;
    assign drive         = drive_reg;
    assign sent          = sent_reg;
    assign left_avoided  = left_count_reg;
    assign right_avoided = right_count_reg;
    assign scan_min_mm   = scan_min_reg;

    // A command is only ever sent as forward or as a turn, never as stop.
    assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg |-> (drive_reg != DRV_STOP))
        else $error("sent flag with a stop command");

    // Each mode holds only the commands that belong to it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ADVANCE) |-> (drive_reg == DRV_FWD))
        else $error("advance mode without forward command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_TURN) |->
            ((drive_reg == DRV_RIGHT || drive_reg == DRV_LEFT)
             && (turn_steps_reg != '0)))
        else $error("turn mode without a turn command or step");

    // The avoidance counters move only with a newly sent turn to the far side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (left_count_reg != $past(left_count_reg)) |->
            (sent_reg && drive_reg == DRV_RIGHT && mode_reg == MODE_TURN))
        else $error("left count changed without a right turn");

    assert property (@(posedge clk) disable iff (!rst_n)
        (right_count_reg != $past(right_count_reg)) |->
            (sent_reg && drive_reg == DRV_LEFT && mode_reg == MODE_TURN))
        else $error("right count changed without a left turn");

endmodule

`default_nettype wire

// ===== sim/obstacle_avoid_turn_controller_check.sv =====
// ----------------------------------------------------------------------------
// Turn controller result checker
// Watches the input, output and register write ports of the turn controller.
// Every input transfer runs through its own copy of the scan window tracker and
// the start, advance and turn mode machine. The command report that comes out
// is queued, and each output transfer is compared field by field with the
// oldest queued report. Failures, queued reports and totals go to the top.
// ----------------------------------------------------------------------------
module obstacle_avoid_turn_controller_check
    import oatc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 op,
    input  logic [RANGE_W-1:0]   range_mm,
    input  logic                 last,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           mode,
    input  logic [1:0]           drive,
    input  logic                 sent,
    input  logic [COUNT_W-1:0]   left_avoided,
    input  logic [COUNT_W-1:0]   right_avoided,
    input  logic [RANGE_W-1:0]   scan_min_mm,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending,
    output int                   checked,
    output int                   turns
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_TICK      = 1'b1;
    localparam int   REPORT_LIMIT = 40;

    typedef struct {
        mode_t              mode;
        drive_t             drive;
        logic               sent;
        logic [COUNT_W-1:0] left_n;
        logic [COUNT_W-1:0] right_n;
        logic [RANGE_W-1:0] scan_min;
    } report_t;

    logic [RANGE_W-1:0] thr_cfg;
    logic [SKIP_W-1:0]  skip_cfg;
    logic [SCAN_W-1:0]  len_cfg;
    logic [ZAI_W-1:0]   zai_cfg;
    logic [TICK_W-1:0]  wait_cfg;
    logic [STEP_W-1:0]  limit_cfg;

    mode_t              cur_mode;
    drive_t             cur_drive;
    logic [IDX_W-1:0]   scan_pos;
    logic [IDX_W-1:0]   low_pos;
    logic [RANGE_W-1:0] low_mm;
    logic [RANGE_W-1:0] last_min;
    logic [TICK_W-1:0]  ticks;
    logic [STEP_W-1:0]  steps;
    logic [COUNT_W-1:0] left_n;
    logic [COUNT_W-1:0] right_n;

    report_t command_reports[$];

    function automatic report_t advance_controller(logic is_tick, logic [RANGE_W-1:0] rng,
                                                   logic is_last);
        report_t            rep;
        logic               fired;
        logic               blocked;
        logic [IDX_W-1:0]   pos;
        fired = 1'b0;
        if (is_tick)
        begin
            if (ticks != TICK_MAX)
                ticks++;
        end
        else
        begin
            if (int'(scan_pos) >= int'(skip_cfg) && int'(scan_pos) + int'(skip_cfg) < int'(len_cfg)
                && rng < low_mm)
            begin
                low_mm  = rng;
                low_pos = scan_pos;
            end
            if (scan_pos != IDX_MAX)
                scan_pos++;
            if (is_last)
            begin
                blocked  = low_mm < thr_cfg;
                pos      = low_pos;
                last_min = low_mm;
                low_mm   = RANGE_MAX;
                low_pos  = '0;
                scan_pos = '0;
                case (cur_mode)
                    MODE_START:
                    begin
                        cur_drive = DRV_FWD;
                        fired     = 1'b1;
                        steps     = '0;
                        cur_mode  = MODE_ADVANCE;
                    end
                    MODE_ADVANCE:
                    begin
                        if (blocked)
                        begin
                            ticks = '0;
                            if (pos > zai_cfg)
                            begin
                                left_n++;
                                cur_drive = DRV_RIGHT;
                            end
                            else
                            begin
                                right_n++;
                                cur_drive = DRV_LEFT;
                            end
                            fired    = 1'b1;
                            steps    = 1;
                            cur_mode = MODE_TURN;
                        end
                    end
                    default:
                    begin
                        if (ticks > wait_cfg)
                        begin
                            if (blocked && steps < limit_cfg)
                            begin
                                ticks = '0;
                                fired = 1'b1;
                                steps++;
                            end
                            else
                            begin
                                cur_drive = DRV_STOP;
                                cur_mode  = MODE_START;
                            end
                        end
                    end
                endcase
            end
        end
        rep.mode     = cur_mode;
        rep.drive    = cur_drive;
        rep.sent     = fired;
        rep.left_n   = left_n;
        rep.right_n  = right_n;
        rep.scan_min = last_min;
        return rep;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t want;
        if (!rst_n)
        begin
            thr_cfg   = 16'd500;
            skip_cfg  = 10'd100;
            len_cfg   = 13'd600;
            zai_cfg   = 12'd300;
            wait_cfg  = 16'd1000;
            limit_cfg = 6'd18;
            cur_mode  = MODE_START;
            cur_drive = DRV_FWD;
            scan_pos  = '0;
            low_pos   = '0;
            low_mm    = RANGE_MAX;
            last_min  = RANGE_MAX;
            ticks     = '0;
            steps     = '0;
            left_n    = '0;
            right_n   = '0;
            command_reports.delete();
            errors    = 0;
            pending   = 0;
            checked   = 0;
            turns     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_THRESHOLD:  thr_cfg   = cfg_data[RANGE_W-1:0];
                    CFG_EDGE_SKIP:  skip_cfg  = cfg_data[SKIP_W-1:0];
                    CFG_SCAN_LEN:   len_cfg   = cfg_data[SCAN_W-1:0];
                    CFG_ZERO_ANGLE: zai_cfg   = cfg_data[ZAI_W-1:0];
                    CFG_WAIT_TICKS: wait_cfg  = cfg_data[TICK_W-1:0];
                    CFG_STEP_LIMIT: limit_cfg = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (command_reports.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $error("Result transfer arrived with no command report pending");
                end
                else
                begin
                    want = command_reports.pop_front();
                    checked++;
                    check_field("mode", 16'(want.mode), 16'(mode));
                    check_field("drive", 16'(want.drive), 16'(drive));
                    check_field("sent", 16'(want.sent), 16'(sent));
                    check_field("left_avoided", want.left_n, left_avoided);
                    check_field("right_avoided", want.right_n, right_avoided);
                    check_field("scan_min_mm", want.scan_min, scan_min_mm);
                end
            end
            if (in_valid && !in_stall)
            begin
                want = advance_controller(op == OP_TICK, range_mm, last);
                if (want.sent && (want.drive == DRV_RIGHT || want.drive == DRV_LEFT))
                    turns++;
                command_reports.push_back(want);
            end
            pending = command_reports.size();
        end
    end

endmodule

// ===== sim/obstacle_avoid_turn_controller_tb.sv =====
// ----------------------------------------------------------------------------
// Turn controller testbench
// Drives range samples and millisecond ticks into the turn controller with
// random gaps and random output stalls, including one long output hold-off.
// A directed part walks every mode change, both turn sides, the empty window
// and a step limit of zero; random scans under random register settings
// follow. The checker beside the block predicts and compares every result;
// this top gives the verdict.
// ----------------------------------------------------------------------------
module obstacle_avoid_turn_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oatc_pkg::*;

    localparam logic OP_RANGE       = 1'b0;
    localparam logic OP_TICK        = 1'b1;
    localparam int   IDLE_PCT       = 14;
    localparam int   HOLD_CYCLES    = 64;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   DRAIN_CYCLES   = 4;
    localparam int   RANDOM_PHASES  = 8;
    localparam int   PHASE_ITEMS    = 120;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 op = 1'b0;
    logic [RANGE_W-1:0]   range_mm = '0;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           mode;
    logic [1:0]           drive;
    logic                 sent;
    logic [COUNT_W-1:0]   left_avoided;
    logic [COUNT_W-1:0]   right_avoided;
    logic [RANGE_W-1:0]   scan_min_mm;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int  errors;
    int  pending;
    int  checked;
    int  turns;
    int  items_sent = 0;
    int  scans_sent = 0;
    int  ticks_sent = 0;
    int  settings_loaded = 0;
    int  holds_asked = 0;
    int  holds_done = 0;
    int  idle_cycles = 0;
    int  cur_thr;
    int  cur_skip;
    int  cur_slen;
    int  cur_wait;
    logic calm = 1'b0;

    obstacle_avoid_turn_controller dut (.*);

    obstacle_avoid_turn_controller_check result_check (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic push(input logic o, input logic [RANGE_W-1:0] r, input logic l);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        range_mm <= r;
        last     <= l;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (o == OP_TICK)
            ticks_sent++;
        else if (l)
            scans_sent++;
    endtask

    task automatic send_tick();
        push(OP_TICK, 16'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
    endtask

    task automatic load_settings(input int thr, input int skip, input int slen,
                                 input int zai, input int wait_ticks, input int lim);
        drain();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_EDGE_SKIP, skip);
        write_reg(CFG_SCAN_LEN, slen);
        write_reg(CFG_ZERO_ANGLE, zai);
        write_reg(CFG_WAIT_TICKS, wait_ticks);
        write_reg(CFG_STEP_LIMIT, lim);
        cfg_we   <= 1'b0;
        cur_thr  = thr;
        cur_skip = skip;
        cur_slen = slen;
        cur_wait = wait_ticks;
        settings_loaded++;
    endtask

    function automatic int pick(int lo_x, int hi_x, int lo, int hi);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return lo_x;
        if (roll < 16)
            return hi_x;
        return $urandom_range(lo, hi);
    endfunction

    task automatic send_scan(input logic blocked);
        int n;
        int lo;
        int hi;
        int hit;
        logic [RANGE_W-1:0] hit_mm;
        logic [RANGE_W-1:0] value;
        if (cur_slen <= 40 && $urandom_range(0, 9) < 7)
            n = cur_slen;
        else
            n = $urandom_range(1, 16);
        lo = cur_skip;
        hi = cur_slen - cur_skip - 1;
        if (hi > n - 1)
            hi = n - 1;
        if (lo <= hi)
            hit = $urandom_range(lo, hi);
        else
            hit = $urandom_range(0, n - 1);
        hit_mm = (cur_thr == 0) ? 16'($urandom) : 16'($urandom_range(0, cur_thr - 1));
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_tick();
            if (blocked && k == hit)
                value = hit_mm;
            else if (blocked && $urandom_range(0, 7) == 0)
                value = $urandom_range(0, 1) ? hit_mm : 16'($urandom_range(0, cur_thr));
            else if ($urandom_range(0, 9) == 0)
                value = 16'($urandom);
            else
                value = 16'($urandom_range(cur_thr, 65535));
            push(OP_RANGE, value, k == n - 1);
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_done < holds_asked)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            out_stall <= !calm && $urandom_range(0, 99) < IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int phase_start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Start, both turn sides with equal minima at straight ahead, the
        // wait before re-evaluation, the step limit and an unblocked stop.
        load_settings(100, 1, 5, 2, 0, 2);
        push(OP_RANGE, 16'hFFFF, 1'b0);
        push(OP_RANGE, 16'd0, 1'b1);
        push(OP_RANGE, 16'd0, 1'b0);
        push(OP_RANGE, 16'd500, 1'b0);
        push(OP_RANGE, 16'd50, 1'b0);
        push(OP_RANGE, 16'd50, 1'b0);
        push(OP_RANGE, 16'd0, 1'b1);
        push(OP_RANGE, 16'd20, 1'b1);
        send_tick();
        push(OP_RANGE, 16'd7, 1'b0);
        push(OP_RANGE, 16'd7, 1'b1);
        send_tick();
        push(OP_RANGE, 16'd7, 1'b0);
        push(OP_RANGE, 16'd7, 1'b1);
        push(OP_RANGE, 16'd9, 1'b1);
        push(OP_RANGE, 16'd900, 1'b0);
        push(OP_RANGE, 16'd900, 1'b0);
        push(OP_RANGE, 16'd900, 1'b0);
        push(OP_RANGE, 16'd99, 1'b1);
        send_tick();
        push(OP_RANGE, 16'd100, 1'b0);
        push(OP_RANGE, 16'd100, 1'b1);

        // A step limit of zero stops the turn at the first re-evaluation.
        load_settings(65535, 0, 1, 0, 0, 0);
        push(OP_RANGE, 16'd5, 1'b1);
        push(OP_RANGE, 16'd65534, 1'b1);
        send_tick();
        push(OP_RANGE, 16'd0, 1'b1);

        // An empty window keeps the minimum at full scale, so nothing blocks.
        load_settings(65535, 1023, MAX_SCAN, 4095, 65535, 63);
        push(OP_RANGE, 16'd0, 1'b1);
        push(OP_RANGE, 16'd0, 1'b0);
        push(OP_RANGE, 16'd0, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            load_settings(pick(0, 65535, 1, 65534), pick(0, 1023, 0, 3), pick(1, MAX_SCAN, 1, 12),
                          pick(0, 4095, 0, 12), pick(0, 65535, 0, 4), pick(1, 63, 1, 5));
            calm = (ph == 2);
            if (ph == 4)
                holds_asked++;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                    push(1'($urandom), 16'($urandom), 1'($urandom));
                else
                begin
                    send_scan(1'($urandom));
                    repeat ($urandom_range(0, (cur_wait < 8) ? cur_wait + 2 : 3)) send_tick();
                end
            end
        end
        calm = 1'b0;

        drain();
        $display("Summary: %0d input transfers (%0d scan ends, %0d ticks) under %0d settings,",
                 items_sent, scans_sent, ticks_sent, settings_loaded);
        $display("Summary: %0d results compared, %0d turn commands, %0d long output hold-off.",
                 checked, turns, holds_done);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
